// File: design/lpl_pkg.sv
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared constants and types for the lookahead peak limiter.
// ----------------------------------------------------------------------------
`default_nettype none
package lpl_pkg;
	localparam int CHANNELS      = 8;
	localparam int MAX_LOOKAHEAD = 64;
	localparam int SAMPLE_BITS   = 24;
	localparam int CH_BITS       = $clog2(CHANNELS);
	localparam int RP_BITS       = $clog2(MAX_LOOKAHEAD);
	localparam int RING_DEPTH    = CHANNELS * MAX_LOOKAHEAD;
	localparam int RING_ABITS    = $clog2(RING_DEPTH);
	localparam int CHAN_W        = 3;
	localparam int COEF_W        = 17;
	localparam int THR_W         = 23;
	localparam int DEC_W         = 5;
	localparam int LA_W          = 7;
	localparam int ENV_W         = 23;
	localparam int PH_W          = 4;
	localparam int STATE_W       = ENV_W + COEF_W + PH_W + RP_BITS;
	localparam logic [COEF_W-1:0] UNITY = 17'd65536;

	localparam logic [2:0] REG_ATTACK    = 3'd0;
	localparam logic [2:0] REG_RELEASE   = 3'd1;
	localparam logic [2:0] REG_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_DECIM     = 3'd3;
	localparam logic [2:0] REG_LOOKAHEAD = 3'd4;

	typedef struct packed {
		logic [ENV_W-1:0]   env;
		logic [COEF_W-1:0]  gain;
		logic [PH_W-1:0]    phase;
		logic [RP_BITS-1:0] rp;
	} chan_state_t;

	// smoothing step: ((65536-c)*old + c*x + 32768) >> 16
	function automatic logic [23:0] smooth(input logic [16:0] c, input logic [23:0] old,
		input logic [23:0] x);
		logic [41:0] s;
		s = 42'({17'd0, 17'(UNITY - c)} * {18'd0, old}) + 42'({25'd0, c} * {18'd0, x})
			+ 42'd32768;
		return s[39:16];
	endfunction
endpackage
`default_nettype wire

// File: design/lpl_ram.sv
// ----------------------------------------------------------------------------
// lpl_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/lpl_div.sv
// ----------------------------------------------------------------------------
// lpl_div
// Restoring divider, one quotient bit per cycle: (thr << 16) / env, capped.
// ----------------------------------------------------------------------------
`default_nettype none
module lpl_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lpl_pkg::THR_W-1:0]  thr,
	input  wire logic [lpl_pkg::ENV_W-1:0]  env,
	output logic                            done,
	output logic [lpl_pkg::COEF_W-1:0]      quot
);
	import lpl_pkg::*;
	localparam int NB = THR_W + 16;
	logic [NB-1:0]     num_q;
	logic [NB-1:0]     q_q;
	logic [ENV_W:0]    rem_q;
	logic [ENV_W-1:0]  den_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [ENV_W+1:0]  trial;

	assign trial = {rem_q, num_q[NB-1]} - {2'b0, den_q};

	// shift in one numerator bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {thr, 16'd0};
			den_q <= env;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			if (!trial[ENV_W+1]) begin
				rem_q <= trial[ENV_W:0];
				q_q   <= {q_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ENV_W-1:0], num_q[NB-1]};
				q_q   <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	assign quot = (q_q > NB'(UNITY)) ? UNITY : q_q[COEF_W-1:0];
endmodule
`default_nettype wire

// File: design/lookahead_peak_limiter_top.sv
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_top
// Per-channel peak limiter with lookahead delay; state held in two RAMs.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, channel, sample_in
//  out     | output    | out_valid, out_stall, channel_out, sample_out, gain_out
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// Each item passes the read, envelope, gain and output states; a divide state
// comes between envelope and gain when its phase is zero and its new envelope
// is nonzero. The bit-serial divider produces 39 quotient bits, and that sets
// the update cost. The state RAM is read at accept and the ring RAM in the
// read state; both are written back in the gain state.
// After reset a clearing pass over all 512 ring addresses zeroes the ring and
// the channel states, each gain set to unity; no input is taken meanwhile.
// A result waits in the output register while out_stall is high. The next
// item is still accepted and is processed up to its output step, where it
// waits until that register is free.
`default_nettype none
module lookahead_peak_limiter_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [lpl_pkg::THR_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [lpl_pkg::CHAN_W-1:0]      channel,
	input  wire logic signed [lpl_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [lpl_pkg::CHAN_W-1:0]           channel_out,
	output logic signed [lpl_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [lpl_pkg::COEF_W-1:0]           gain_out
);
	import lpl_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_ENV   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_GAIN  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [COEF_W-1:0] att_q, rel_q;
	logic [THR_W-1:0]  thr_q;
	logic [DEC_W-1:0]  dec_q;
	logic [LA_W-1:0]   la_q;
	logic [RING_ABITS-1:0] clr_q;

	logic [CHAN_W-1:0]      chan_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic [ENV_W-1:0]       env_q;
	logic [COEF_W-1:0]      g_q;
	logic [PH_W-1:0]        ph_q;
	logic [RP_BITS-1:0]     rp_q;
	logic [SAMPLE_BITS-1:0] d_q;
	logic [COEF_W-1:0]      tgt_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= 17'd6554; rel_q <= 17'd655; thr_q <= 23'd8388607;
			dec_q <= 5'd4; la_q <= 7'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK:    att_q <= cfg_data[COEF_W-1:0];
				REG_RELEASE:   rel_q <= cfg_data[COEF_W-1:0];
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_DECIM:     dec_q <= cfg_data[DEC_W-1:0];
				REG_LOOKAHEAD: la_q  <= cfg_data[LA_W-1:0];
				default: ;
			endcase
		end
	end

	logic [COEF_W-1:0] att, rel;
	logic [4:0] dec;
	logic [RP_BITS:0] del;
	assign att = (att_q > UNITY) ? UNITY : att_q;
	assign rel = (rel_q > UNITY) ? UNITY : rel_q;
	assign dec = (dec_q == 5'd0) ? 5'd1 : ((dec_q > 5'd16) ? 5'd16 : dec_q);
	assign del = (la_q > LA_W'(MAX_LOOKAHEAD)) ? (RP_BITS+1)'(MAX_LOOKAHEAD)
		: (RP_BITS+1)'(la_q);

	logic [CH_BITS-1:0] ch_idx;
	assign ch_idx = chan_q[CH_BITS-1:0];

	logic in_acc;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	// load the output register when it is empty or being drained
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// channel state RAM
	chan_state_t st_rd, st_wr;
	logic st_we;
	logic [CH_BITS-1:0] st_wa;
	lpl_ram #(.WIDTH(STATE_W), .DEPTH(CHANNELS)) u_state (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wr),
		.raddr(channel[CH_BITS-1:0]), .rdata(st_rd));

	// delay ring RAM, addressed {channel, slot}
	logic [RP_BITS-1:0] rd_slot;
	logic [SAMPLE_BITS-1:0] ring_rd, ring_wd;
	logic ring_we;
	logic [RING_ABITS-1:0] ring_wa;
	assign rd_slot = st_rd.rp - RP_BITS'(del);
	lpl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_DEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(ring_wa), .wdata(ring_wd),
		.raddr({ch_idx, rd_slot}), .rdata(ring_rd));

	// magnitude and envelope step
	logic [SAMPLE_BITS-1:0] mag;
	logic [ENV_W-1:0] env_new;
	logic [SAMPLE_BITS-1:0] env_sm;
	always_comb begin
		mag = x_q[SAMPLE_BITS-1] ? (~x_q + 1'b1) : x_q;
		if (mag[SAMPLE_BITS-1]) mag = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		env_sm = smooth((mag > SAMPLE_BITS'(env_q)) ? att : rel,
			SAMPLE_BITS'(env_q), mag);
		env_new = env_sm[ENV_W-1:0];
	end

	logic div_start, div_done;
	logic [COEF_W-1:0] div_q;
	lpl_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .thr(thr_q),
		.env(env_new), .done(div_done), .quot(div_q));

	logic [SAMPLE_BITS-1:0] g_sm;
	assign g_sm = smooth((tgt_q < g_q) ? att : rel, SAMPLE_BITS'(g_q), SAMPLE_BITS'(tgt_q));

	// output product
	logic [SAMPLE_BITS-1:0] dmag;
	logic [SAMPLE_BITS+COEF_W-1:0] prod;
	logic [SAMPLE_BITS+1:0] pm;
	logic signed [SAMPLE_BITS+2:0] y;
	always_comb begin
		dmag = d_q[SAMPLE_BITS-1] ? (~d_q + 1'b1) : d_q;
		prod = {{COEF_W{1'b0}}, dmag} * {{SAMPLE_BITS{1'b0}}, g_q} + (SAMPLE_BITS+COEF_W)'(32768);
		pm = {1'b0, prod[SAMPLE_BITS+COEF_W-1:16]};
		y = d_q[SAMPLE_BITS-1] ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
	end

	logic [PH_W:0] ph_inc;
	assign ph_inc = {1'b0, ph_q} + 1'b1;

	always_comb begin
		st_we = 1'b0; st_wa = ch_idx; st_wr = '0;
		ring_we = 1'b0; ring_wa = {ch_idx, rp_q}; ring_wd = x_q;
		div_start = 1'b0;
		if (state_q == ST_CLEAR) begin
			ring_we = 1'b1; ring_wa = clr_q; ring_wd = '0;
			st_we = 1'b1; st_wa = clr_q[CH_BITS-1:0];
			st_wr.gain = UNITY;
		end else if (state_q == ST_GAIN) begin
			// write back the updated state and push the sample into the ring
			st_we = 1'b1; ring_we = 1'b1;
			st_wr.env = env_q;
			st_wr.gain = (ph_q == '0) ? g_sm[COEF_W-1:0] : g_q;
			st_wr.rp = rp_q + 1'b1;
			st_wr.phase = (ph_inc >= dec) ? '0 : ph_inc[PH_W-1:0];
		end
		if (state_q == ST_ENV) div_start = (ph_q == '0) && (env_new != '0);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RING_ABITS'(RING_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_acc) state_q <= ST_READ;
				ST_READ: state_q <= ST_ENV;
				ST_ENV: begin
					if (ph_q != '0) state_q <= ST_GAIN;
					else if (env_new == '0) state_q <= ST_GAIN;
					else state_q <= ST_DIV;
				end
				ST_DIV: if (div_done) state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_OUT;
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				chan_q <= channel; x_q <= sample_in;
			end
			ST_READ: begin
				env_q <= st_rd.env; g_q <= st_rd.gain; ph_q <= st_rd.phase; rp_q <= st_rd.rp;
				tgt_q <= UNITY;
			end
			ST_ENV: begin
				d_q <= (del == '0) ? x_q : ring_rd;
				if (ph_q == '0) env_q <= env_new;
			end
			ST_DIV: if (div_done) tgt_q <= div_q;
			ST_GAIN: if (ph_q == '0) g_q <= g_sm[COEF_W-1:0];
			ST_OUT: if (out_load) begin
				channel_out <= chan_q;
				gain_out    <= g_q;
				sample_out  <= (y > $signed((SAMPLE_BITS+3)'(8388607))) ? 24'h7FFFFF
					: (y < -$signed((SAMPLE_BITS+3)'(8388608))) ? 24'h800000
					: y[SAMPLE_BITS-1:0];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
